@@ rtl/sbcdec_pkg.sv @@
`default_nettype none

package sbcdec_pkg;

  localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
  localparam logic [7:0] OP_REZERO          = 8'h01;
  localparam logic [7:0] OP_FORMAT_UNIT     = 8'h04;
  localparam logic [7:0] OP_READ6           = 8'h08;
  localparam logic [7:0] OP_WRITE6          = 8'h0A;
  localparam logic [7:0] OP_SEEK6           = 8'h0B;
  localparam logic [7:0] OP_START_STOP      = 8'h1B;
  localparam logic [7:0] OP_PREVENT_ALLOW   = 8'h1E;
  localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
  localparam logic [7:0] OP_READ10          = 8'h28;
  localparam logic [7:0] OP_WRITE10         = 8'h2A;
  localparam logic [7:0] OP_SEEK10          = 8'h2B;
  localparam logic [7:0] OP_VERIFY10        = 8'h2F;
  localparam logic [7:0] OP_PREFETCH        = 8'h34;
  localparam logic [7:0] OP_SYNC_CACHE      = 8'h35;
  localparam logic [7:0] OP_LOCK_UNLOCK     = 8'h36;

  localparam logic [1:0] KEY_NONE            = 2'd0;
  localparam logic [1:0] KEY_NOT_READY       = 2'd1;
  localparam logic [1:0] KEY_ILLEGAL_REQUEST = 2'd2;

  localparam logic [2:0] ASC_NONE            = 3'd0;
  localparam logic [2:0] ASC_INVALID_FIELD   = 3'd1;
  localparam logic [2:0] ASC_NO_MEDIUM       = 3'd2;
  localparam logic [2:0] ASC_WRITE_PROTECTED = 3'd3;
  localparam logic [2:0] ASC_LBA_RANGE       = 3'd4;
  localparam logic [2:0] ASC_START_NEEDED    = 3'd5;
  localparam logic [2:0] ASC_NOT_REPORTABLE  = 3'd6;

  localparam logic [1:0] PHASE_UNCHANGED = 2'd0;
  localparam logic [1:0] PHASE_STATUS    = 2'd1;
  localparam logic [1:0] PHASE_DATA_IN   = 2'd2;
  localparam logic [1:0] PHASE_DATA_OUT  = 2'd3;

  localparam logic [1:0] REG_CAPACITY_BLOCKS  = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE_BYTES = 2'd1;
  localparam logic [1:0] REG_WRITE_PROTECT    = 2'd2;
  localparam logic [1:0] REG_MEDIUM_PRESENT   = 2'd3;

  localparam logic [13:0] CAPACITY_DATA_LEN  = 14'd8;
  localparam logic [13:0] FORMAT_HEADER_LEN  = 14'd4;
  localparam logic [15:0] COUNT6_ZERO_BLOCKS = 16'd256;
  localparam logic [13:0] BLOCK_SIZE_RESET   = 14'd512;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
    logic [7:0] byte8;
    logic       card_init_ok;
  } cdb_t;

  typedef struct packed {
    logic [31:0] capacity_blocks;
    logic [13:0] block_size_bytes;
    logic        write_protect;
    logic        medium_present;
  } cfg_t;

  typedef struct packed {
    logic        handled;
    logic        status_fail;
    logic [1:0]  sense_key;
    logic [2:0]  sense_asc;
    logic [1:0]  next_phase;
    logic        xfer_write;
    logic [31:0] xfer_lba;
    logic [15:0] xfer_blocks;
    logic        multi_block;
    logic [13:0] data_len;
    logic [63:0] capacity_reply;
    logic        format_header_pending;
  } result_t;

  typedef struct packed {
    logic unit_started;
    logic card_initialised;
  } unit_state_t;

  function automatic result_t set_fail(result_t r, logic [1:0] key, logic [2:0] asc);
    result_t o;
    o = r;
    o.status_fail = 1'b1;
    o.sense_key = key;
    o.sense_asc = asc;
    o.next_phase = PHASE_STATUS;
    return o;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sbcdec_core.sv @@
`default_nettype none

module sbcdec_core (
  input  wire sbcdec_pkg::cdb_t        cdb,
  input  wire sbcdec_pkg::cfg_t        cfg,
  input  wire sbcdec_pkg::unit_state_t state,
  output sbcdec_pkg::unit_state_t      state_next,
  output sbcdec_pkg::result_t          res
);

  logic [31:0] lba6;
  logic [31:0] lba10;
  logic [15:0] cnt6;
  logic [15:0] cnt10;
  logic        is_rw6;
  logic [31:0] rw_lba;
  logic [15:0] rw_cnt;
  logic [32:0] rw_end;
  logic        rw_range_bad;
  logic        end_at_cap;
  logic [31:0] seek_lba;
  logic        not_started;
  logic        not_present;
  logic        not_init;
  logic        ready;

  assign lba6  = {11'd0, cdb.byte1[4:0], cdb.byte2, cdb.byte3};
  assign lba10 = {cdb.byte2, cdb.byte3, cdb.byte4, cdb.byte5};
  assign cnt6  = (cdb.byte4 == 8'd0) ? sbcdec_pkg::COUNT6_ZERO_BLOCKS : {8'd0, cdb.byte4};
  assign cnt10 = {cdb.byte7, cdb.byte8};

  assign is_rw6 = (cdb.opcode == sbcdec_pkg::OP_READ6) || (cdb.opcode == sbcdec_pkg::OP_WRITE6);
  assign rw_lba = is_rw6 ? lba6 : lba10;
  assign rw_cnt = is_rw6 ? cnt6 : cnt10;
  assign rw_end = {1'b0, rw_lba} + {17'd0, rw_cnt};
  assign rw_range_bad = rw_end > {1'b0, cfg.capacity_blocks};
  assign end_at_cap   = rw_end == {1'b0, cfg.capacity_blocks};

  assign seek_lba = (cdb.opcode == sbcdec_pkg::OP_SEEK6) ? lba6 : lba10;

  assign not_started = !state.unit_started;
  assign not_present = !cfg.medium_present;
  assign not_init    = !state.card_initialised;
  assign ready       = !not_started && !not_present && !not_init;

  always_comb begin
    res = '0;
    res.handled = 1'b1;
    state_next = state;
    if (cdb.opcode == sbcdec_pkg::OP_START_STOP) begin
      if (cdb.byte4[0]) begin
        state_next.unit_started = 1'b1;
        if (!state.card_initialised) begin
          state_next.card_initialised = cdb.card_init_ok;
        end
      end else begin
        state_next.unit_started = 1'b0;
      end
    end else if (!ready) begin
      if (not_started) begin
        res = sbcdec_pkg::set_fail(res, sbcdec_pkg::KEY_NOT_READY,
                                   sbcdec_pkg::ASC_START_NEEDED);
      end else if (not_present) begin
        res = sbcdec_pkg::set_fail(res, sbcdec_pkg::KEY_NOT_READY,
                                   sbcdec_pkg::ASC_NO_MEDIUM);
      end else begin
        res = sbcdec_pkg::set_fail(res, sbcdec_pkg::KEY_NOT_READY,
                                   sbcdec_pkg::ASC_NOT_REPORTABLE);
      end
    end else begin
      case (cdb.opcode)
        sbcdec_pkg::OP_TEST_UNIT_READY: begin
        end
        sbcdec_pkg::OP_FORMAT_UNIT: begin
          if (cdb.byte1[4]) begin
            res.data_len = sbcdec_pkg::FORMAT_HEADER_LEN;
            res.next_phase = sbcdec_pkg::PHASE_DATA_OUT;
            res.format_header_pending = 1'b1;
          end
        end
        sbcdec_pkg::OP_READ6, sbcdec_pkg::OP_READ10: begin
          if (rw_range_bad) begin
            res = sbcdec_pkg::set_fail(res, sbcdec_pkg::KEY_ILLEGAL_REQUEST,
                                       sbcdec_pkg::ASC_LBA_RANGE);
          end else begin
            res.next_phase = sbcdec_pkg::PHASE_DATA_IN;
            res.xfer_lba = rw_lba;
            res.xfer_blocks = rw_cnt;
            res.multi_block = !((rw_cnt == 16'd1) || end_at_cap);
          end
        end
        sbcdec_pkg::OP_WRITE6, sbcdec_pkg::OP_WRITE10: begin
          if (cfg.write_protect) begin
            res = sbcdec_pkg::set_fail(res, sbcdec_pkg::KEY_ILLEGAL_REQUEST,
                                       sbcdec_pkg::ASC_WRITE_PROTECTED);
          end else if (rw_range_bad) begin
            res = sbcdec_pkg::set_fail(res, sbcdec_pkg::KEY_ILLEGAL_REQUEST,
                                       sbcdec_pkg::ASC_LBA_RANGE);
          end else begin
            res.next_phase = sbcdec_pkg::PHASE_DATA_OUT;
            res.xfer_write = 1'b1;
            res.xfer_lba = rw_lba;
            res.xfer_blocks = rw_cnt;
            res.multi_block = 1'b1;
            res.data_len = cfg.block_size_bytes;
          end
        end
        sbcdec_pkg::OP_READ_CAPACITY: begin
          if (!cdb.byte8[0] && (lba10 != 32'd0)) begin
            res = sbcdec_pkg::set_fail(res, sbcdec_pkg::KEY_ILLEGAL_REQUEST,
                                       sbcdec_pkg::ASC_INVALID_FIELD);
          end else if (cfg.capacity_blocks != 32'd0) begin
            res.capacity_reply = {cfg.capacity_blocks - 32'd1, 18'd0, cfg.block_size_bytes};
            res.data_len = sbcdec_pkg::CAPACITY_DATA_LEN;
            res.next_phase = sbcdec_pkg::PHASE_DATA_IN;
          end else begin
            res = sbcdec_pkg::set_fail(res, sbcdec_pkg::KEY_NOT_READY,
                                       sbcdec_pkg::ASC_NO_MEDIUM);
          end
        end
        sbcdec_pkg::OP_SEEK6, sbcdec_pkg::OP_SEEK10: begin
          if (seek_lba >= cfg.capacity_blocks) begin
            res = sbcdec_pkg::set_fail(res, sbcdec_pkg::KEY_ILLEGAL_REQUEST,
                                       sbcdec_pkg::ASC_LBA_RANGE);
          end
        end
        sbcdec_pkg::OP_LOCK_UNLOCK, sbcdec_pkg::OP_PREFETCH, sbcdec_pkg::OP_PREVENT_ALLOW,
        sbcdec_pkg::OP_REZERO, sbcdec_pkg::OP_SYNC_CACHE: begin
        end
        sbcdec_pkg::OP_VERIFY10: begin
          if (cdb.byte1[1]) begin
            res = sbcdec_pkg::set_fail(res, sbcdec_pkg::KEY_ILLEGAL_REQUEST,
                                       sbcdec_pkg::ASC_INVALID_FIELD);
          end
        end
        default: begin
          res.handled = 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/sbcdec_cfg_regs.sv @@
`default_nettype none

module sbcdec_cfg_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [1:0]       wr_index,
  input  wire logic [31:0]      wr_data,
  output sbcdec_pkg::cfg_t      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity_blocks  <= 32'd0;
      cfg.block_size_bytes <= sbcdec_pkg::BLOCK_SIZE_RESET;
      cfg.write_protect    <= 1'b0;
      cfg.medium_present   <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        sbcdec_pkg::REG_CAPACITY_BLOCKS:  cfg.capacity_blocks  <= wr_data;
        sbcdec_pkg::REG_BLOCK_SIZE_BYTES: cfg.block_size_bytes <= wr_data[13:0];
        sbcdec_pkg::REG_WRITE_PROTECT:    cfg.write_protect    <= wr_data[0];
        sbcdec_pkg::REG_MEDIUM_PRESENT:   cfg.medium_present   <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/scsi_block_command_decoder.sv @@
`default_nettype none

// Direct-access SCSI command decoder. Each input transaction carries one command
// descriptor (bytes 0 to 8) and gives exactly one result transaction: status, sense,
// next phase and transfer setup. A descriptor is captured in an input register,
// decoded combinationally against the started and card-initialised flags and the
// configuration, and the result is held in an output register; one command per
// cycle is sustained while out_stall is low. START STOP UNIT updates the flags at the
// decode edge, so the following command already sees them. Configuration writes are
// always ready and must only be issued while no command is in flight.
module scsi_block_command_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  cdb_opcode,
  input  wire logic [7:0]  cdb_byte1,
  input  wire logic [7:0]  cdb_byte2,
  input  wire logic [7:0]  cdb_byte3,
  input  wire logic [7:0]  cdb_byte4,
  input  wire logic [7:0]  cdb_byte5,
  input  wire logic [7:0]  cdb_byte6,
  input  wire logic [7:0]  cdb_byte7,
  input  wire logic [7:0]  cdb_byte8,
  input  wire logic        card_init_ok,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             handled,
  output logic             status_fail,
  output logic [1:0]       sense_key,
  output logic [2:0]       sense_asc,
  output logic [1:0]       next_phase,
  output logic             xfer_write,
  output logic [31:0]      xfer_lba,
  output logic [15:0]      xfer_blocks,
  output logic             multi_block,
  output logic [13:0]      data_len,
  output logic [63:0]      capacity_reply,
  output logic             format_header_pending
);

  sbcdec_pkg::cfg_t        cfg;
  sbcdec_pkg::cdb_t        cdb;
  logic                    cdb_valid;
  sbcdec_pkg::unit_state_t state;
  sbcdec_pkg::unit_state_t state_next;
  sbcdec_pkg::result_t     res_next;
  sbcdec_pkg::result_t     res;
  logic                    advance;

  assign cfg_ready = 1'b1;

  sbcdec_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // decode stage moves when the result register is free or being taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = cdb_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cdb_valid <= 1'b0;
    end else if (!in_stall) begin
      cdb_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cdb <= '{opcode: cdb_opcode, byte1: cdb_byte1, byte2: cdb_byte2,
               byte3: cdb_byte3, byte4: cdb_byte4, byte5: cdb_byte5,
               byte6: cdb_byte6, byte7: cdb_byte7, byte8: cdb_byte8,
               card_init_ok: card_init_ok};
    end
  end

  sbcdec_core u_core (
    .cdb        (cdb),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.unit_started     <= 1'b1;
      state.card_initialised <= 1'b0;
    end else if (cdb_valid && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= cdb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cdb_valid && advance) begin
      res <= res_next;
    end
  end

  assign handled               = res.handled;
  assign status_fail           = res.status_fail;
  assign sense_key             = res.sense_key;
  assign sense_asc             = res.sense_asc;
  assign next_phase            = res.next_phase;
  assign xfer_write            = res.xfer_write;
  assign xfer_lba              = res.xfer_lba;
  assign xfer_blocks           = res.xfer_blocks;
  assign multi_block           = res.multi_block;
  assign data_len              = res.data_len;
  assign capacity_reply        = res.capacity_reply;
  assign format_header_pending = res.format_header_pending;

endmodule

`default_nettype wire
